// ----- rtl/core/ple_pkg.sv -----
// Shared constants, codes and types of the positional list engine.
package ple_pkg;

	localparam int DEPTH  = 64;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 2;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GRP    = 8;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_GET    = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REDUCE
	} state_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic                    shift_ins;
		logic                    shift_del;
		logic                    sel_en;
		logic [CMP_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} bcast_t;

endpackage

// ----- rtl/core/ple_if.sv -----
// Request and response channel interfaces of the positional list engine.
interface ple_req_if;
	import ple_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, command, position, value, input ready);
	modport sink   (input valid, command, position, value, output ready);
endinterface

interface ple_rsp_if;
	import ple_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] read_value;
	logic [LEN_W-1:0]        length;

	modport source (output valid, status, read_value, length, input ready);
	modport sink   (input valid, status, read_value, length, output ready);
endinterface

// ----- rtl/core/ple_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors and drives the read bus.
module ple_cell (
	input  logic                            clk,
	input  ple_pkg::bcast_t                 bcast,
	input  logic [ple_pkg::CMP_W-1:0]       slot,
	input  logic signed [ple_pkg::VAL_W-1:0] left_data,
	input  logic signed [ple_pkg::VAL_W-1:0] right_data,
	output logic signed [ple_pkg::VAL_W-1:0] data,
	output logic signed [ple_pkg::VAL_W-1:0] rd_data
);
	import ple_pkg::*;

	logic signed [VAL_W-1:0] entry_q;
	logic                    hit;
	logic                    after;

	// slot is this cell's one-based position in the list.
	assign hit   = (slot == bcast.pos);
	assign after = (slot > bcast.pos);

	always_ff @(posedge clk) begin
		if (bcast.shift_ins) begin
			if (hit) begin
				entry_q <= bcast.value;
			end else if (after) begin
				entry_q <= left_data;
			end
		end else if (bcast.shift_del) begin
			if (hit || after) begin
				entry_q <= right_data;
			end
		end
	end

	assign data    = entry_q;
	assign rd_data = (bcast.sel_en && hit) ? entry_q : '0;

endmodule

// ----- rtl/core/ple_or_tree.sv -----
// Two-level OR tree that collects the one selected entry from the cell chain.
module ple_or_tree (
	input  logic                            clk,
	input  logic                            load,
	input  logic signed [ple_pkg::VAL_W-1:0] words [ple_pkg::DEPTH],
	output logic signed [ple_pkg::VAL_W-1:0] result
);
	import ple_pkg::*;

	logic signed [VAL_W-1:0] grp_d  [NGRP];
	logic signed [VAL_W-1:0] grp_s1 [NGRP];

	// Unselected cells drive zero, so an OR gives the selected word.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					grp_d[g] = grp_d[g] | words[g * GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp_d;
		end
	end

	always_comb begin
		result = '0;
		for (int g = 0; g < NGRP; g++) begin
			result = result | grp_s1[g];
		end
	end

endmodule

// ----- rtl/core/positional_list_engine_top.sv -----
// Top level of the positional list engine: control, cell chain, read tree and output register.

// The engine keeps an ordered list of up to DEPTH (64) signed 32-bit values,
// addressed by one-based position. Every request (insert, delete or get) gives
// exactly one response with a status, the value read or removed, and the list
// length after the operation. A request passes through an accept step, in
// which it is captured, an execute step, in which every cell of the chain
// compares its own position with the requested one and shifts toward or away
// from its neighbor in parallel, and a reduce step for the second level of
// the OR tree that gathers the selected entry into the output register. The
// engine works on one request at a time and takes no new request before the
// last one has left the reduce step; it can accept the next request while the
// previous response is still waiting in the output register, and it only
// stalls when that register is still full at the end of the next request.
// Reset empties the list at once; entry contents need no clearing because only
// positions up to the current length are ever read.
module positional_list_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	ple_req_if.sink           req,
	ple_rsp_if.source         rsp
);
	import ple_pkg::*;

	state_t state_q, state_d;

	// Captured request.
	logic [CMD_W-1:0]        cmd_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;

	logic [CNT_W-1:0] count_q, count_d;

	// Results of the execute cycle, carried into the reduce cycle.
	status_t          status_s1;
	logic [LEN_W-1:0] length_s1;

	// Output register.
	logic                    out_valid_q;
	status_t                 status_q;
	logic signed [VAL_W-1:0] rdval_q;
	logic [LEN_W-1:0]        length_q;

	logic accept;
	logic exec;
	logic load_out;

	status_t          exec_status;
	logic             do_ins;
	logic             do_del;
	logic             rd_ok;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W:0]   cnt_p1;

	bcast_t                  bcast;
	logic signed [VAL_W-1:0] cell_data [DEPTH];
	logic signed [VAL_W-1:0] cell_rd   [DEPTH];
	logic signed [VAL_W-1:0] tree_out;

	// State sequencing.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_REDUCE;
			end
			S_REDUCE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		req.ready = 1'b0;
		exec      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE:   req.ready = 1'b1;
			S_EXEC:   exec = 1'b1;
			S_REDUCE: load_out = !out_valid_q || rsp.ready;
			default:  req.ready = 1'b0;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			pos_q <= req.position;
			val_q <= req.value;
		end
	end

	// Position checks against the current length. The position check comes
	// before the full-list check on insert.
	assign pos_w  = CMP_W'(pos_q);
	assign cnt_w  = CMP_W'(count_q);
	assign cnt_p1 = {1'b0, cnt_w} + 1'b1;

	always_comb begin
		exec_status = ST_OK;
		do_ins      = 1'b0;
		do_del      = 1'b0;
		rd_ok       = 1'b0;
		count_d     = count_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (pos_q == '0 || {1'b0, pos_w} > cnt_p1) begin
					exec_status = ST_BAD_POS;
				end else if (count_q == CNT_W'(DEPTH)) begin
					exec_status = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos_q == '0 || pos_w > cnt_w) begin
					exec_status = ST_BAD_POS;
				end else begin
					do_del  = 1'b1;
					rd_ok   = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_GET: begin
				if (pos_q == '0 || pos_w > cnt_w) begin
					exec_status = ST_BAD_POS;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
				// The unused command code leaves the list alone and reports ok.
				exec_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_s1 <= exec_status;
			length_s1 <= LEN_W'(count_d);
		end
	end

	// Every cell sees the same control; each decides from its own position.
	assign bcast.shift_ins = exec && do_ins;
	assign bcast.shift_del = exec && do_del;
	assign bcast.sel_en    = exec && rd_ok;
	assign bcast.pos       = pos_w;
	assign bcast.value     = val_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_in;
		logic signed [VAL_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_left
			assign left_in = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_right
			assign right_in = cell_data[i+1];
		end

		ple_cell u_cell (
			.clk        (clk),
			.bcast      (bcast),
			.slot       (CMP_W'(i + 1)),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// The read tree samples the cells during the execute cycle, before they shift.
	ple_or_tree u_or_tree (
		.clk    (clk),
		.load   (exec),
		.words  (cell_rd),
		.result (tree_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_s1;
			rdval_q  <= tree_out;
			length_q <= length_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = rdval_q;
	assign rsp.length     = length_q;

	// The list never holds more than DEPTH entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list length exceeds its depth");

	// The length only moves as the result of an execute cycle.
	a_count_exec_only: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(count_q))
		else $error("list length changed outside an execute cycle");

	// A rejected request leaves the length unchanged.
	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && exec_status != ST_OK) |=> $stable(count_q))
		else $error("rejected request changed the list length");

	// A finished request always shows up as a valid response.
	a_reduce_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (rsp.valid && state_q == S_IDLE))
		else $error("finished request did not reach the output register");

	// No request is taken while one is still being worked on.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC && !req.ready))
		else $error("request accepted while another was in flight");

endmodule
